// File: sv/ilir_pkg.sv
// Shared types, operation and status codes for the indexed list block.
package ilir_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_APPEND = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;
    localparam logic [2:0] OP_SETLEN = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [6:0]         index;
        logic signed [31:0] value;
        logic [6:0]         new_length;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [6:0]         length;
        logic [1:0]         status;
    } rsp_item_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic               take;
        logic               rd;
        logic               wr;
        logic               ins;
        logic               rem;
        logic               fill;
        logic signed [31:0] value;
    } cell_cmd_t;

endpackage

// File: sv/ilir_cell.sv
// One storage cell of the list: holds one word and trades it with its neighbors.
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CMPW     = 7,
    parameter bit IS_LAST  = 1'b0
)
(
    input  logic                clk,
    input  cell_cmd_t           cmd,
    input  logic [CMPW-1:0]     pos,
    input  logic [CMPW-1:0]     count,
    input  logic [CMPW-1:0]     new_length,
    input  logic signed [31:0]  left_word,
    input  logic signed [31:0]  right_word,
    output logic signed [31:0]  word,
    output logic signed [31:0]  rd_word
);

    localparam logic [CMPW-1:0] MY_IDX = CMPW'(CELL_IDX);

    logic signed [31:0] word_reg;
    logic signed [31:0] word_next;
    logic signed [31:0] rd_word_reg;

    always_comb
    begin
        word_next = word_reg;
        if (cmd.take)
        begin
            if ((cmd.wr || cmd.ins) && MY_IDX == pos)
            begin
                word_next = cmd.value;
            end
            else if (cmd.ins && MY_IDX > pos)
            begin
                word_next = left_word;
            end
            else if (cmd.rem && MY_IDX >= pos && !IS_LAST)
            begin
                word_next = right_word;
            end
            else if (cmd.fill && MY_IDX >= count && MY_IDX < new_length)
            begin
                word_next = cmd.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (cmd.take)
        begin
            rd_word_reg <= (cmd.rd && MY_IDX == pos) ? word_reg : '0;
        end
    end

    assign word    = word_reg;
    assign rd_word = rd_word_reg;

endmodule

// File: sv/indexed_list_insert_remove.sv
// Top level of the indexed list: control, status decode and the row of cells.
// A result passes the staging register and then the output register after its request transfer.
// Throughput: one request per cycle while req_stall is low; every cell updates in the cycle of the transfer.
// The response path has a staging register and an output register, so one further
// request is still accepted while a result waits to be taken.
// Reset empties the list; stored words are undefined until written.
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    // Count width holds CAPACITY itself; compares run at a width that also fits
    // the seven-bit request fields.
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [CMPW-1:0] CAP_W = CMPW'(CAPACITY);

    logic [CW-1:0]   count_reg;
    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] idx_w;
    logic [CMPW-1:0] nl_w;
    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_next_w;
    logic [1:0]      status;
    cell_cmd_t       cmd;
    logic            accept;

    logic            s1_valid_reg;
    logic [6:0]      s1_len_reg;
    logic [1:0]      s1_status_reg;
    logic            advance;

    logic            rsp_valid_reg;
    rsp_item_t       rsp_reg;

    logic signed [31:0] words    [CAPACITY];
    logic signed [31:0] rd_words [CAPACITY];
    logic signed [31:0] rd_or;

    assign accept = req_valid && !req_stall;
    assign cnt_w  = CMPW'(count_reg);
    assign idx_w  = CMPW'(req.index);
    assign nl_w   = CMPW'(req.new_length);

    // Decode the request against the current length. A failing request leaves
    // every cell and the length alone; only the status reports it.
    always_comb
    begin
        cmd        = '0;
        cmd.take   = accept;
        cmd.value  = req.value;
        pos_w      = idx_w;
        status     = ST_OK;
        cnt_next_w = cnt_w;
        unique case (req.func)
            OP_READ:
            begin
                if (idx_w < cnt_w)
                begin
                    cmd.rd = 1'b1;
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            OP_WRITE:
            begin
                if (idx_w < cnt_w)
                begin
                    cmd.wr = 1'b1;
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            OP_APPEND:
            begin
                // Appending is an insert at the current end of the list.
                if (cnt_w >= CAP_W)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.ins    = 1'b1;
                    pos_w      = cnt_w;
                    cnt_next_w = cnt_w + 1'b1;
                end
            end
            OP_INSERT:
            begin
                // The position check takes precedence over the full check.
                if (idx_w > cnt_w)
                begin
                    status = ST_RANGE;
                end
                else if (cnt_w >= CAP_W)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.ins    = 1'b1;
                    cnt_next_w = cnt_w + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (idx_w >= cnt_w)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    cmd.rem    = 1'b1;
                    cnt_next_w = cnt_w - 1'b1;
                end
            end
            OP_SETLEN:
            begin
                // Growing fills the new slots; shrinking keeps the words in place.
                if (nl_w > CAP_W)
                begin
                    status = ST_OVER;
                end
                else
                begin
                    cmd.fill   = 1'b1;
                    cnt_next_w = nl_w;
                end
            end
            default:
            begin
                // Unused operation codes are ignored.
            end
        endcase
    end

    // The row of cells. Each cell sees its left and right neighbor's word so
    // that insert shifts everything above the position up by one place and
    // remove shifts everything from the position down by one place.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_word;
        logic signed [31:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_inner_left
            assign left_word = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = words[i];
        end
        else
        begin : g_inner_right
            assign right_word = words[i+1];
        end

        ilir_cell #(
            .CELL_IDX (i),
            .CMPW     (CMPW),
            .IS_LAST  (i == CAPACITY - 1)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos_w),
            .count      (cnt_w),
            .new_length (nl_w),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i]),
            .rd_word    (rd_words[i])
        );
    end

    // At most one cell presents a nonzero read word, so an OR collects it.
    always_comb
    begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rd_or = rd_or | rd_words[k];
        end
    end

    // The staging register moves on whenever the output register is free or
    // its result is being transferred in this cycle.
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && rsp_valid_reg && rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg    <= CW'(cnt_next_w);
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_len_reg    <= 7'(cnt_next_w);
            s1_status_reg <= status;
        end
        if (advance)
        begin
            rsp_reg.read_data <= rd_or;
            rsp_reg.length    <= s1_len_reg;
            rsp_reg.status    <= s1_status_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: sv/ilir_checker.sv
// Port-level checks for the indexed list, bound to the top level.
module ilir_checker
    import ilir_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    localparam logic [6:0] CAP_LEN = 7'(CAPACITY);

    // A result held back by the receiver stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Requests are only held off when a result is waiting at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without a waiting result");

    // Read data is zero unless the request succeeded.
    a_rdata_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.read_data != 0 |-> rsp.status == ST_OK)
        else $error("nonzero read data on a failed request");

    // A full report only comes with the list at capacity.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.length == CAP_LEN)
        else $error("full status with list below capacity");

    // A request accepted into an idle block has its result at the output after passing the staging register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
        else $error("result missing after a request transfer");

endmodule

bind indexed_list_insert_remove ilir_checker #(.CAPACITY(CAPACITY)) u_ilir_checker (.*);
